[design/exs_pkg.sv]
package exs_pkg;

  // Capacity of the cell row and element width
  localparam int MAX_ELEMS  = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(MAX_ELEMS + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]             count_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } state_t;

  // Control from the sequencer to the cell row
  typedef struct packed {
    logic  shift;      // move every held element one cell toward the head
    logic  ins_valid;  // element entering the head cell
    data_t ins_data;
  } chain_ctrl_t;

endpackage

[design/exs_cell.sv]
module exs_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  logic          in_valid,     // element arriving from the left neighbor
  input  exs_pkg::data_t in_data,
  input  logic          nb_valid,     // held element of the right neighbor
  input  exs_pkg::data_t nb_data,
  output logic          held_valid,
  output exs_pkg::data_t held_data,
  output logic          carry_valid,  // element handed to the right neighbor
  output exs_pkg::data_t carry_data
);

  logic           held_valid_r, held_valid_nxt;
  exs_pkg::data_t held_data_r, held_data_nxt;
  logic           carry_valid_r, carry_valid_nxt;
  exs_pkg::data_t carry_data_r, carry_data_nxt;

  // Keep the smaller element, pass the larger one on; or shift toward the head
  always_comb begin
    held_valid_nxt  = held_valid_r;
    held_data_nxt   = held_data_r;
    carry_valid_nxt = 1'b0;
    carry_data_nxt  = carry_data_r;
    if (shift) begin
      held_valid_nxt = nb_valid;
      held_data_nxt  = nb_data;
    end else if (in_valid) begin
      if (!held_valid_r) begin
        held_valid_nxt = 1'b1;
        held_data_nxt  = in_data;
      end else if (in_data < held_data_r) begin
        held_data_nxt   = in_data;
        carry_valid_nxt = 1'b1;
        carry_data_nxt  = held_data_r;
      end else begin
        carry_valid_nxt = 1'b1;
        carry_data_nxt  = in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      carry_valid_r <= 1'b0;
    end else begin
      held_valid_r  <= held_valid_nxt;
      carry_valid_r <= carry_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_data_r  <= held_data_nxt;
    carry_data_r <= carry_data_nxt;
  end

  assign held_valid  = held_valid_r;
  assign held_data   = held_data_r;
  assign carry_valid = carry_valid_r;
  assign carry_data  = carry_data_r;

endmodule

[design/exs_chain.sv]
module exs_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  exs_pkg::chain_ctrl_t ctrl,
  output logic                 busy,       // an element is still moving along the row
  output logic                 head_valid,
  output exs_pkg::data_t       head_data,
  output logic                 spill        // element pushed past the last cell
);

  logic           cv   [0:exs_pkg::MAX_ELEMS];
  exs_pkg::data_t cd   [0:exs_pkg::MAX_ELEMS];
  logic           hv   [0:exs_pkg::MAX_ELEMS];
  exs_pkg::data_t hd   [0:exs_pkg::MAX_ELEMS];
  logic [exs_pkg::MAX_ELEMS-1:0] moving;

  // Feed the head cell; the slot past the tail reads as empty
  assign cv[0] = ctrl.ins_valid;
  assign cd[0] = ctrl.ins_data;
  assign hv[exs_pkg::MAX_ELEMS] = 1'b0;
  assign hd[exs_pkg::MAX_ELEMS] = '0;

  for (genvar i = 0; i < exs_pkg::MAX_ELEMS; i++) begin : g_cell
    exs_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift       (ctrl.shift),
      .in_valid    (cv[i]),
      .in_data     (cd[i]),
      .nb_valid    (hv[i+1]),
      .nb_data     (hd[i+1]),
      .held_valid  (hv[i]),
      .held_data   (hd[i]),
      .carry_valid (cv[i+1]),
      .carry_data  (cd[i+1])
    );
    assign moving[i] = cv[i+1];
  end

  assign busy       = |moving;
  assign head_valid = hv[0];
  assign head_data  = hd[0];
  // Never set while the set size is capped at the row length
  assign spill      = cv[exs_pkg::MAX_ELEMS];

endmodule

[design/exchange_sorter.sv]
// Channel  Dir  Ports                       Contents
// in_      in   tvalid tready tdata tlast   tdata: value[31:0]; tlast: is_last
// out_     out  tvalid tready tdata tlast   tdata: sorted_value[31:0]; tlast: final_res;
//               tuser                        tuser: overflow
//
// Elements enter a row of MAX_ELEMS insertion cells at one per cycle; each cell keeps the
// smaller element and passes the larger one right, one cell per cycle.
// After the last element, the row settles until no element is moving along it; then
// results leave from the head cell at one per cycle while out_tready is high, and the
// row shifts left as each one is taken. in_tready is low during settle and drain;
// out_tready low holds the head result.
// Reset (rst_n low, synchronous) empties the row and returns to loading.
module exchange_sorter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [exs_pkg::DATA_WIDTH-1:0] in_tdata,   // [31:0] value
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [exs_pkg::DATA_WIDTH-1:0] out_tdata,  // [31:0] sorted_value
  output logic                          out_tlast,
  output logic                          out_tuser    // [0] overflow
);

  exs_pkg::state_t      state_r, state_nxt;
  exs_pkg::count_t      count_r, count_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 ent_valid_r, ent_valid_nxt;
  exs_pkg::data_t       ent_data_r;
  exs_pkg::chain_ctrl_t ctrl;
  logic                 busy, head_valid, spill;
  exs_pkg::data_t       head_data;
  logic                 in_xfer, out_xfer, full;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign full     = (count_r == exs_pkg::count_t'(exs_pkg::MAX_ELEMS));

  // Sequence load, settle and drain
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    ent_valid_nxt = 1'b0;
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    unique case (state_r)
      exs_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            ent_valid_nxt = 1'b1;
            count_nxt     = count_r + exs_pkg::count_t'(1);
          end
          if (in_tlast) begin
            state_nxt = exs_pkg::ST_SETTLE;
          end
        end
      end
      exs_pkg::ST_SETTLE: begin
        if (!busy && !ent_valid_r) begin
          state_nxt = exs_pkg::ST_DRAIN;
        end
      end
      exs_pkg::ST_DRAIN: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          count_nxt = count_r - exs_pkg::count_t'(1);
          if (out_tlast) begin
            dropped_nxt = 1'b0;
            state_nxt   = exs_pkg::ST_LOAD;
          end
        end
      end
      default: state_nxt = exs_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= exs_pkg::ST_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      ent_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      ent_valid_r <= ent_valid_nxt;
    end
  end

  // Register the accepted element on its way to the head cell
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ent_data_r <= in_tdata;
    end
  end

  assign ctrl.shift     = out_xfer;
  assign ctrl.ins_valid = ent_valid_r;
  assign ctrl.ins_data  = ent_data_r;

  exs_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .busy       (busy),
    .head_valid (head_valid),
    .head_data  (head_data),
    .spill      (spill)
  );

  assign out_tdata = head_data;
  assign out_tlast = (count_r == exs_pkg::count_t'(1));
  assign out_tuser = dropped_r;

`ifndef SYNTHESIS
  // Input and output sides are never open at once
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output open together");

  // Every offered result comes from an occupied head cell
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> head_valid)
    else $error("result offered from empty head cell");

  // The held count never passes the row length
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= exs_pkg::count_t'(exs_pkg::MAX_ELEMS))
    else $error("element count past capacity");

  // Nothing is pushed off the tail of the row
  a_spill: assert property (@(posedge clk) disable iff (!rst_n)
    !spill)
    else $error("element lost past the last cell");

  // The final result transfer reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> (in_tready && !dropped_r && count_r == '0))
    else $error("set not closed after final result");
`endif

endmodule

[tb/tb_exchange_sorter.sv]
module tb_exchange_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int             WATCHDOG_LIMIT = 4000;
  localparam int             TAIL_CYCLES    = exs_pkg::MAX_ELEMS + 8;
  localparam int             PHASE_ITEMS    = 8;
  localparam exs_pkg::data_t ELEM_MIN       = {1'b1, {(exs_pkg::DATA_WIDTH-1){1'b0}}};
  localparam exs_pkg::data_t ELEM_MAX       = {1'b0, {(exs_pkg::DATA_WIDTH-1){1'b1}}};

  // One element on its way in, and one sorted value on its way out
  typedef struct {
    exs_pkg::data_t value;
    logic           last;
  } elem_item_t;

  typedef struct {
    exs_pkg::data_t value;
    logic           fin;
    logic           ovf;
  } sorted_res_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [exs_pkg::DATA_WIDTH-1:0] in_tdata   = '0;   // [31:0] value
  logic                           in_tlast   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [exs_pkg::DATA_WIDTH-1:0] out_tdata;         // [31:0] sorted_value
  logic                           out_tlast;
  logic                           out_tuser;         // [0] overflow

  elem_item_t  elem_q[$];     // elements waiting for the driver
  sorted_res_t sorted_q[$];   // sorted values still owed by the block

  // Shadow of the block's current set
  exs_pkg::data_t set_elems [exs_pkg::MAX_ELEMS];
  int             set_count   = 0;
  logic           set_dropped = 1'b0;

  int   n_pushed    = 0;
  int   n_taken     = 0;
  int   n_errors    = 0;
  int   idle_cycles = 0;
  int   send_idle   = 0;
  int   recv_stall  = 0;
  logic in_acc      = 1'b0;

  exchange_sorter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic note_error(string msg);
    if (n_errors < 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
    n_errors++;
  endtask

  // Keep the element, or drop it when the set is full; on the last one sort the
  // set with pairwise exchanges and queue one sorted value per held element
  task automatic absorb_element(exs_pkg::data_t v, logic last);
    exs_pkg::data_t held;
    sorted_res_t    r;
    int             i;
    int             j;
    if (set_count < exs_pkg::MAX_ELEMS) begin
      set_elems[set_count] = v;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      for (i = 0; i < set_count; i++) begin
        for (j = i + 1; j < set_count; j++) begin
          if (set_elems[i] > set_elems[j]) begin
            held         = set_elems[i];
            set_elems[i] = set_elems[j];
            set_elems[j] = held;
          end
        end
      end
      for (i = 0; i < set_count; i++) begin
        r.value = set_elems[i];
        r.fin   = (i == set_count - 1);
        r.ovf   = set_dropped;
        sorted_q.push_back(r);
      end
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic add_item(exs_pkg::data_t v, logic last);
    elem_item_t it;
    it.value = v;
    it.last  = last;
    elem_q.push_back(it);
    n_pushed++;
  endtask

  // Mix extremes, a narrow band around zero for duplicates, and full-range values
  function automatic exs_pkg::data_t rand_elem();
    case ($urandom_range(9))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2, 3, 4: return exs_pkg::data_t'($urandom_range(10)) - exs_pkg::data_t'(5);
      default: return exs_pkg::data_t'($urandom);
    endcase
  endfunction

  task automatic add_random_set(int size);
    int k;
    for (k = 0; k < size; k++) begin
      add_item(rand_elem(), k == size - 1);
    end
  endtask

  // Hold off new sets until every element is taken and every result is back
  task automatic drain_all();
    while (n_taken != n_pushed || sorted_q.size() != 0) @(posedge clk);
  endtask

  // Input driver: hold an untaken transfer, otherwise offer the next element
  always @(negedge clk) begin
    elem_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_acc) begin
      in_tvalid <= 1'b1;
    end else if (elem_q.size() != 0 && $urandom_range(99) >= send_idle) begin
      it = elem_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= it.value;
      in_tlast  <= it.last;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall);
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    sorted_res_t want;
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      absorb_element(exs_pkg::data_t'(in_tdata), in_tlast);
      n_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (sorted_q.size() == 0) begin
        note_error($sformatf("unexpected result value=%0d last=%b ovf=%b",
                             $signed(out_tdata), out_tlast, out_tuser));
      end else begin
        want = sorted_q.pop_front();
        if (out_tdata !== want.value || out_tlast !== want.fin ||
            out_tuser !== want.ovf) begin
          note_error($sformatf(
            "mismatch: exp value=%0d last=%b ovf=%b, got value=%0d last=%b ovf=%b",
            want.value, want.fin, want.ovf, $signed(out_tdata), out_tlast, out_tuser));
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  // Watchdog: give up when no transfer happens for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int phase;
    int quota;
    int size;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets: lone element, extremes, duplicates, reversed order
    add_item(exs_pkg::data_t'(7), 1'b1);
    add_item(ELEM_MAX, 1'b0);
    add_item(ELEM_MIN, 1'b0);
    add_item(exs_pkg::data_t'(0), 1'b0);
    add_item(exs_pkg::data_t'(-1), 1'b0);
    add_item(exs_pkg::data_t'(1), 1'b1);
    add_item(exs_pkg::data_t'(5), 1'b0);
    add_item(exs_pkg::data_t'(5), 1'b0);
    add_item(exs_pkg::data_t'(-3), 1'b0);
    add_item(exs_pkg::data_t'(5), 1'b0);
    add_item(exs_pkg::data_t'(-3), 1'b1);
    for (size = 3; size >= -2; size--) begin
      add_item(exs_pkg::data_t'(size), size == -2);
    end
    add_item(ELEM_MAX, 1'b0);
    add_item(ELEM_MAX, 1'b0);
    add_item(ELEM_MIN, 1'b0);
    add_item(ELEM_MIN, 1'b1);
    drain_all();

    // Random sets over four idling phases; one exactly full set, one overflowing
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 82; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 82; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      quota = n_pushed + PHASE_ITEMS;
      if (phase == 1) begin
        add_random_set(exs_pkg::MAX_ELEMS);
      end
      if (phase == 2) begin
        add_random_set(exs_pkg::MAX_ELEMS + $urandom_range(1, 3));
      end
      while (n_pushed < quota) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        add_random_set(size);
      end
      drain_all();
    end

    // Let any stray results surface before judging
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sorted_q.size() != 0) begin
      note_error($sformatf("%0d results never arrived", sorted_q.size()));
    end
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
